>>> sv/midi_note_voice_allocator_assert.svh
// Assertion macros for the MIDI note voice allocator.
`ifndef MIDI_NOTE_VOICE_ALLOCATOR_ASSERT_SVH
`define MIDI_NOTE_VOICE_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define MNVA_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("midi_note_voice_allocator: assertion failed");

// Check that a consequence holds in the cycle after its trigger.
`define MNVA_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("midi_note_voice_allocator: assertion failed");

`else

`define MNVA_ASSERT_ALWAYS(label, cond)
`define MNVA_ASSERT_NEXT(label, trig, cons)

`endif

`endif

>>> sv/mnva_pkg.sv
// Shared constants, codes and types of the MIDI note voice allocator.
package mnva_pkg;

  localparam int VOICE_COUNT_DEF = 5;

  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ON   = 2'd1;
  localparam logic [1:0] KIND_OFF  = 2'd2;

  localparam logic [2:0] EV_ASSIGNED  = 3'd0;
  localparam logic [2:0] EV_NO_VOICE  = 3'd1;
  localparam logic [2:0] EV_RELEASED  = 3'd2;
  localparam logic [2:0] EV_UNMATCHED = 3'd3;
  localparam logic [2:0] EV_IGNORED   = 3'd4;

  typedef struct packed {
    logic       start;
    logic [1:0] kind;
    logic [7:0] note;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

>>> sv/mnva_voice_bank.sv
// Voice store with a one-voice-per-cycle compare unit for claim and release scans.
module mnva_voice_bank
  import mnva_pkg::*;
#(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF,
  parameter int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  scan_req_t              req,
  output scan_rsp_t              rsp,
  output logic [IDX_W-1:0]       hit_index,
  output logic [VOICE_COUNT-1:0] playing
);

  logic             busy;
  logic [IDX_W-1:0] idx;
  logic [1:0]       kind;
  logic [7:0]       note;
  logic [7:0]       voice_note [VOICE_COUNT];
  logic             match;
  logic             last;

  assign last = (idx == IDX_W'(VOICE_COUNT - 1));

  always_comb begin
    if (kind == KIND_ON) begin
      match = !playing[idx];
    end else begin
      match = playing[idx] && (voice_note[idx] == note);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      idx     <= '0;
      playing <= '0;
      rsp     <= '0;
    end else begin
      rsp.done <= !req.start && busy && (match || last);
      if (req.start) begin
        busy <= 1'b1;
        idx  <= '0;
        kind <= req.kind;
        note <= req.note;
      end else if (busy) begin
        if (match) begin
          playing[idx] <= (kind == KIND_ON);
          if (kind == KIND_ON) begin
            voice_note[idx] <= note;
          end
          busy      <= 1'b0;
          rsp.hit   <= 1'b1;
          hit_index <= idx;
        end else if (last) begin
          busy      <= 1'b0;
          rsp.hit   <= 1'b0;
          hit_index <= '0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

endmodule

>>> sv/midi_note_voice_allocator.sv
// Top level of the MIDI note voice allocator: byte framing, scan sequencing, result register.
//
// Usage: the rx channel (rx_valid, rx_stall, rx_byte) takes one MIDI byte per beat.
// Bytes are grouped by position in threes: status, note, velocity. Only the
// velocity byte yields a result beat on the ev channel (ev_valid, ev_stall,
// event_kind, voice_index, note_number, velocity, active_mask).
// Status and note bytes are taken with no result.
// A velocity byte of a note-on or note-off group starts a scan that compares one
// voice per cycle in the shared compare unit, lowest voice first, until a match or
// the last voice (1 to VOICE_COUNT voices visited); the result then passes through
// the emit state into the output register. An ignored group skips the scan.
// rx_stall is high from the velocity beat until the result is loaded into the
// output register, so at most one group is in work at a time.
// The output register holds a finished result while ev_stall is high; a new
// byte is still taken then, and a further result waits in the sequencer.
// Reset (rst, synchronous) frees every voice, returns to the status position
// and empties the output register.
module midi_note_voice_allocator
  import mnva_pkg::*;
#(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       ev_valid,
  input  logic       ev_stall,
  output logic [2:0] event_kind,
  output logic [2:0] voice_index,
  output logic [7:0] note_number,
  output logic [7:0] velocity,
  output logic [4:0] active_mask
);

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [1:0] PH_STATUS = 2'd0;
  localparam logic [1:0] PH_NOTE   = 2'd1;
  localparam logic [1:0] PH_VEL    = 2'd2;

  logic [1:0]             state;
  logic [1:0]             byte_phase;
  logic [1:0]             message_kind;
  logic [7:0]             held_note;
  logic [7:0]             held_velocity;
  logic [2:0]             res_kind;
  logic [2:0]             res_index;
  scan_req_t              req;
  scan_rsp_t              rsp;
  logic [IDX_W-1:0]       hit_index;
  logic [VOICE_COUNT-1:0] playing;
  logic [4:0]             mask;
  logic                   emit_go;
  logic                   ev_voiced;

  assign rx_stall  = (state != ST_IDLE);
  assign emit_go   = (state == ST_EMIT) && (!ev_valid || !ev_stall);
  assign ev_voiced = (event_kind == EV_ASSIGNED) || (event_kind == EV_RELEASED);

  always_comb begin
    req.start = (state == ST_IDLE) && rx_valid && (byte_phase == PH_VEL) &&
                (message_kind != KIND_NONE);
    req.kind  = message_kind;
    req.note  = held_note;
  end

  for (genvar i = 0; i < 5; i++) begin : g_mask
    if (i < VOICE_COUNT) begin : g_live
      assign mask[i] = playing[i];
    end else begin : g_none
      assign mask[i] = 1'b0;
    end
  end

  mnva_voice_bank #(
    .VOICE_COUNT(VOICE_COUNT),
    .IDX_W      (IDX_W)
  ) u_bank (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .hit_index(hit_index),
    .playing  (playing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      byte_phase   <= PH_STATUS;
      message_kind <= KIND_NONE;
      held_note    <= 8'd0;
      ev_valid     <= 1'b0;
    end else begin
      if (emit_go) begin
        ev_valid <= 1'b1;
      end else if (ev_valid && !ev_stall) begin
        ev_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (rx_valid) begin
            case (byte_phase)
              PH_NOTE: begin
                held_note  <= rx_byte;
                byte_phase <= PH_VEL;
              end
              PH_VEL: begin
                byte_phase    <= PH_STATUS;
                held_velocity <= rx_byte;
                if (message_kind == KIND_NONE) begin
                  res_kind  <= EV_IGNORED;
                  res_index <= 3'd0;
                  state     <= ST_EMIT;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: begin
                if (rx_byte == STATUS_NOTE_OFF) begin
                  message_kind <= KIND_OFF;
                end else if (rx_byte == STATUS_NOTE_ON) begin
                  message_kind <= KIND_ON;
                end else begin
                  message_kind <= KIND_NONE;
                end
                byte_phase <= PH_NOTE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (rsp.done) begin
            state        <= ST_EMIT;
            message_kind <= KIND_NONE;
            if (rsp.hit) begin
              res_kind  <= (message_kind == KIND_ON) ? EV_ASSIGNED : EV_RELEASED;
              res_index <= 3'(hit_index);
            end else begin
              res_kind  <= (message_kind == KIND_ON) ? EV_NO_VOICE : EV_UNMATCHED;
              res_index <= 3'd0;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            event_kind  <= res_kind;
            voice_index <= res_index;
            note_number <= held_note;
            velocity    <= held_velocity;
            active_mask <= mask;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "midi_note_voice_allocator_assert.svh"

  `MNVA_ASSERT_ALWAYS(a_done_in_scan, !rsp.done || (state == ST_SCAN))
  `MNVA_ASSERT_NEXT(a_emit_loads, emit_go, ev_valid && (state == ST_IDLE))
  `MNVA_ASSERT_ALWAYS(a_index_zero, !ev_valid || ev_voiced || (voice_index == 3'd0))

endmodule
